// File: hw/rtl/hba_pkg.sv
// Shared constants, types and codes of the heap block allocator.
`timescale 1ns / 1ps
package hba_pkg;

    localparam int CHUNK_UNITS = 256;
    localparam int MAX_CHUNKS  = 16;
    localparam int MAX_BLOCKS  = 64;

    localparam int TOTAL_UNITS = CHUNK_UNITS * MAX_CHUNKS;
    localparam int START_W     = $clog2(TOTAL_UNITS);
    localparam int SIZE_W      = $clog2(TOTAL_UNITS + 1);
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int CHK_W       = $clog2(MAX_CHUNKS + 1);
    localparam int NEED_W      = 14;
    localparam int SZC_W       = ((SIZE_W > NEED_W) ? SIZE_W : NEED_W) + 1;
    localparam int CMP_W       = ((START_W + 5) > 16) ? (START_W + 5) : 17;

    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_FIRST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SIZE_ZERO = 2'd1,
        ST_OOM       = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               is_free;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: hw/rtl/hba_req_if.sv
// Request channel: command, size and address with valid/ready.
`timescale 1ns / 1ps
interface hba_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] size_bytes;
    logic [15:0] address;

    modport source (output valid, cmd, size_bytes, address, input ready);
    modport sink   (input valid, cmd, size_bytes, address, output ready);
endinterface

// File: hw/rtl/hba_rsp_if.sv
// Response channel: data address and status with valid/ready.
`timescale 1ns / 1ps
interface hba_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_address;
    logic [1:0]  status;

    modport source (output valid, data_address, status, input ready);
    modport sink   (input valid, data_address, status, output ready);
endinterface

// File: hw/rtl/hba_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module hba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/heap_block_allocator.sv
// Top level of the heap block allocator: sequencer around the block table RAM.
`timescale 1ns / 1ps
// Usage:
//   req (sink): one beat per command. cmd selects allocate or free; size_bytes is
//     the payload of an allocate, address the data offset of a free.
//   rsp (source): one beat per request with data_address and status.
//   i_cfg_we / i_cfg_wdata: write the fit strategy (best, first, worst, next).
//     Write only while no request is in flight.
// The block table lives in a 64-entry RAM read one entry at a time (address state,
// then data state). Each request scans the table in address order:
//   allocate: one search pass over the blocks, one more pass per chunk
//     added, one mark-lookup pass for next fit, plus the entries moved
//     on a split; free: a lookup pass plus the entries moved on each
//     merge. The worst case is next fit over a large table while all chunks
//     are added; a zero size or null free goes straight to the done state,
//     and the next request is taken once its response is registered.
// A new request is taken only when the sequencer is idle; the finished response
// sits in an output register, so the next request may start while it waits.
// Reset (synchronous, active low) empties the table, drops all chunks, clears the
// next-fit mark and selects best fit. No clearing pass is needed: only entries
// below the block count are ever read.
module heap_block_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hba_req_if.sink             req,
    hba_rsp_if.source           rsp,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata
);
    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_PICK     = 16'h0002,
        S_SCAN_RD  = 16'h0004,
        S_SCAN_DT  = 16'h0008,
        S_CHOSE    = 16'h0010,
        S_GROW     = 16'h0020,
        S_SPLIT_WR = 16'h0040,
        S_ALLOC_WR = 16'h0080,
        S_LEFT_RD  = 16'h0100,
        S_LEFT_DT  = 16'h0200,
        S_RIGHT_RD = 16'h0400,
        S_RIGHT_DT = 16'h0800,
        S_FREE_WR  = 16'h1000,
        S_SH_RD    = 16'h2000,
        S_SH_WR    = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    typedef enum logic [1:0] {
        SM_MARK,
        SM_PICK,
        SM_FREE
    } t_scan_mode;

    t_state                          r_state;
    t_state                          r_ret;
    t_scan_mode                      r_mode;
    logic [1:0]                      r_strategy;
    logic [hba_pkg::CNT_W-1:0]       r_count;
    logic [hba_pkg::CHK_W-1:0]       r_chunks;
    logic [hba_pkg::START_W-1:0]     r_mark;
    logic                            r_mark_vld;
    logic [hba_pkg::IDX_W-1:0]       r_idx;
    logic [hba_pkg::CNT_W-1:0]       r_left;
    logic                            r_found;
    logic [hba_pkg::IDX_W-1:0]       r_c;
    logic [hba_pkg::START_W-1:0]     r_c_start;
    logic [hba_pkg::SIZE_W-1:0]      r_c_size;
    logic [hba_pkg::SIZE_W-1:0]      r_best;
    logic [hba_pkg::NEED_W-1:0]      r_need;
    logic [15:0]                     r_address;
    logic [hba_pkg::IDX_W-1:0]       r_k;
    logic [hba_pkg::IDX_W-1:0]       r_sh;
    logic [hba_pkg::IDX_W-1:0]       r_sh_end;
    logic                            r_sh_dn;
    logic [hba_pkg::START_W-1:0]     r_cur_start;
    logic [hba_pkg::SIZE_W-1:0]      r_cur_size;
    logic [15:0]                     r_res_data;
    hba_pkg::t_status                r_res_status;
    logic                            r_out_vld;
    logic [15:0]                     r_out_data;
    hba_pkg::t_status                r_out_status;

    logic                            ram_we;
    logic [hba_pkg::IDX_W-1:0]       ram_waddr;
    hba_pkg::t_entry                 ram_wdata;
    logic [hba_pkg::IDX_W-1:0]       ram_raddr;
    logic [hba_pkg::ENTRY_W-1:0]     ram_rdata;
    hba_pkg::t_entry                 ent;

    logic                            scan_last;
    logic [hba_pkg::IDX_W-1:0]       scan_nxt;
    logic                            ent_fit;
    logic                            mark_hit;
    logic [hba_pkg::SIZE_W-1:0]      ent_diff;
    logic [hba_pkg::CMP_W-1:0]       ent_daddr;
    logic [hba_pkg::CMP_W-1:0]       c_daddr;
    logic [hba_pkg::NEED_W-1:0]      in_need;
    logic [hba_pkg::SZC_W-1:0]       need_plus3;
    logic                            table_full;

    hba_ram #(
        .WIDTH (hba_pkg::ENTRY_W),
        .DEPTH (hba_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent        = hba_pkg::t_entry'(ram_rdata);
    assign scan_last  = (r_left == hba_pkg::CNT_W'(1));
    assign scan_nxt   = ((hba_pkg::CNT_W'(r_idx) + hba_pkg::CNT_W'(1)) == r_count)
                        ? '0 : r_idx + hba_pkg::IDX_W'(1);
    assign ent_fit    = ent.is_free
                        && (hba_pkg::SZC_W'(ent.size) >= hba_pkg::SZC_W'(r_need));
    assign mark_hit   = ent.is_free && (ent.start == r_mark);
    assign ent_diff   = ent.size - hba_pkg::SIZE_W'(r_need);
    assign ent_daddr  = (hba_pkg::CMP_W'(ent.start) << 4) + hba_pkg::CMP_W'(32);
    assign c_daddr    = (hba_pkg::CMP_W'(r_c_start) << 4) + hba_pkg::CMP_W'(32);
    assign in_need    = hba_pkg::NEED_W'(((18'(req.size_bytes) + 18'd15) >> 4) + 18'd2);
    assign need_plus3 = hba_pkg::SZC_W'(r_need) + hba_pkg::SZC_W'(3);
    assign table_full = (r_count >= hba_pkg::CNT_W'(hba_pkg::MAX_BLOCKS));

    assign req.ready        = (r_state == S_IDLE);
    assign rsp.valid        = r_out_vld;
    assign rsp.data_address = r_out_data;
    assign rsp.status       = r_out_status;

    // RAM port drive
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = '{start: r_cur_start, size: r_cur_size, is_free: 1'b1};
        ram_raddr = r_idx;
        unique case (r_state)
            S_GROW: begin
                ram_waddr = r_count[hba_pkg::IDX_W-1:0];
                ram_wdata = '{start: hba_pkg::START_W'(hba_pkg::START_W'(r_chunks)
                                     * hba_pkg::START_W'(hba_pkg::CHUNK_UNITS)),
                              size: hba_pkg::SIZE_W'(hba_pkg::CHUNK_UNITS),
                              is_free: 1'b1};
                ram_we    = (r_chunks < hba_pkg::CHK_W'(hba_pkg::MAX_CHUNKS))
                            && !table_full;
            end
            S_SPLIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_c + hba_pkg::IDX_W'(1);
                ram_wdata = '{start: r_c_start + hba_pkg::START_W'(r_need),
                              size: r_c_size - hba_pkg::SIZE_W'(r_need),
                              is_free: 1'b1};
            end
            S_ALLOC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_c;
                ram_wdata = '{start: r_c_start, size: r_c_size, is_free: 1'b0};
            end
            S_FREE_WR: begin
                ram_we    = 1'b1;
            end
            S_LEFT_RD: ram_raddr = r_k - hba_pkg::IDX_W'(1);
            S_RIGHT_RD: ram_raddr = r_k + hba_pkg::IDX_W'(1);
            S_SH_RD: ram_raddr = r_sh_dn ? r_sh - hba_pkg::IDX_W'(1)
                                         : r_sh + hba_pkg::IDX_W'(1);
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sh;
                ram_wdata = ent;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_mode     <= SM_PICK;
            r_strategy <= hba_pkg::FIT_BEST;
            r_count    <= '0;
            r_chunks   <= '0;
            r_mark_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_strategy <= i_cfg_wdata;
            end
            if (rsp.ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req.valid) begin
                        r_need     <= in_need;
                        r_address  <= req.address;
                        r_res_data <= '0;
                        if (req.cmd == hba_pkg::CMD_ALLOC) begin
                            if (req.size_bytes == 16'd0) begin
                                r_res_status <= hba_pkg::ST_SIZE_ZERO;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_PICK;
                            end
                        end else if (req.address == 16'd0) begin
                            r_res_status <= hba_pkg::ST_OK;
                            r_state      <= S_DONE;
                        end else if (r_count == '0) begin
                            r_res_status <= hba_pkg::ST_BAD_FREE;
                            r_state      <= S_DONE;
                        end else begin
                            r_mode  <= SM_FREE;
                            r_idx   <= '0;
                            r_left  <= r_count;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_PICK: begin
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_idx   <= '0;
                    r_left  <= r_count;
                    if (r_count == '0) begin
                        r_state <= S_GROW;
                    end else begin
                        r_mode  <= (r_strategy == hba_pkg::FIT_NEXT && r_mark_vld)
                                   ? SM_MARK : SM_PICK;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_DT;
                S_SCAN_DT: begin
                    case (r_mode)
                        SM_MARK: begin
                            // restart as a circular pick after the mark, or from 0
                            if (mark_hit || scan_last) begin
                                r_mode <= SM_PICK;
                                r_left <= r_count;
                                r_idx  <= mark_hit ? scan_nxt : '0;
                            end else begin
                                r_left <= r_left - hba_pkg::CNT_W'(1);
                                r_idx  <= scan_nxt;
                            end
                            r_state <= S_SCAN_RD;
                        end
                        SM_PICK: begin
                            logic take;
                            logic stop;
                            take = 1'b0;
                            stop = 1'b0;
                            case (r_strategy)
                                hba_pkg::FIT_BEST: take = ent_fit
                                                          && (!r_found || ent_diff < r_best);
                                hba_pkg::FIT_WORST: take = ent_fit && ent.size > r_best;
                                default: begin
                                    take = ent_fit;
                                    stop = ent_fit;
                                end
                            endcase
                            if (take) begin
                                r_found   <= 1'b1;
                                r_c       <= r_idx;
                                r_c_start <= ent.start;
                                r_c_size  <= ent.size;
                                r_best    <= (r_strategy == hba_pkg::FIT_BEST)
                                             ? ent_diff : ent.size;
                            end
                            r_idx   <= scan_nxt;
                            r_left  <= r_left - hba_pkg::CNT_W'(1);
                            r_state <= (stop || scan_last) ? S_CHOSE : S_SCAN_RD;
                        end
                        default: begin
                            r_idx  <= scan_nxt;
                            r_left <= r_left - hba_pkg::CNT_W'(1);
                            if (!ent.is_free && ent_daddr == hba_pkg::CMP_W'(r_address)) begin
                                r_k         <= r_idx;
                                r_cur_start <= ent.start;
                                r_cur_size  <= ent.size;
                                r_state     <= S_LEFT_RD;
                            end else if (scan_last) begin
                                r_res_status <= hba_pkg::ST_BAD_FREE;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                    endcase
                end
                S_CHOSE: begin
                    if (!r_found) begin
                        r_state <= S_GROW;
                    end else if (hba_pkg::SZC_W'(r_c_size) >= need_plus3 && !table_full) begin
                        // open a slot after the chosen block
                        r_sh     <= r_count[hba_pkg::IDX_W-1:0];
                        r_sh_end <= r_c + hba_pkg::IDX_W'(1);
                        r_sh_dn  <= 1'b1;
                        r_count  <= r_count + hba_pkg::CNT_W'(1);
                        r_ret    <= S_SPLIT_WR;
                        r_state  <= S_SH_RD;
                    end else begin
                        r_state <= S_ALLOC_WR;
                    end
                end
                S_GROW: begin
                    if (r_chunks >= hba_pkg::CHK_W'(hba_pkg::MAX_CHUNKS) || table_full) begin
                        r_res_status <= hba_pkg::ST_OOM;
                        r_state      <= S_DONE;
                    end else begin
                        r_count  <= r_count + hba_pkg::CNT_W'(1);
                        r_chunks <= r_chunks + hba_pkg::CHK_W'(1);
                        r_state  <= S_PICK;
                    end
                end
                S_SPLIT_WR: begin
                    r_c_size <= hba_pkg::SIZE_W'(r_need);
                    r_state  <= S_ALLOC_WR;
                end
                S_ALLOC_WR: begin
                    r_res_data   <= c_daddr[15:0];
                    r_res_status <= hba_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                S_LEFT_RD: begin
                    r_state <= (r_k == '0) ? S_RIGHT_RD : S_LEFT_DT;
                end
                S_LEFT_DT: begin
                    if (ent.is_free) begin
                        r_cur_start <= ent.start;
                        r_cur_size  <= r_cur_size + ent.size;
                        r_sh        <= r_k;
                        r_sh_end    <= hba_pkg::IDX_W'(r_count - hba_pkg::CNT_W'(1));
                        r_sh_dn     <= 1'b0;
                        r_count     <= r_count - hba_pkg::CNT_W'(1);
                        r_k         <= r_k - hba_pkg::IDX_W'(1);
                        r_ret       <= S_RIGHT_RD;
                        r_state     <= S_SH_RD;
                    end else begin
                        r_state <= S_RIGHT_RD;
                    end
                end
                S_RIGHT_RD: begin
                    r_state <= ((hba_pkg::CNT_W'(r_k) + hba_pkg::CNT_W'(1)) < r_count)
                               ? S_RIGHT_DT : S_FREE_WR;
                end
                S_RIGHT_DT: begin
                    if (ent.is_free) begin
                        r_cur_size <= r_cur_size + ent.size;
                        r_sh       <= r_k + hba_pkg::IDX_W'(1);
                        r_sh_end   <= hba_pkg::IDX_W'(r_count - hba_pkg::CNT_W'(1));
                        r_sh_dn    <= 1'b0;
                        r_count    <= r_count - hba_pkg::CNT_W'(1);
                        r_ret      <= S_FREE_WR;
                        r_state    <= S_SH_RD;
                    end else begin
                        r_state <= S_FREE_WR;
                    end
                end
                S_FREE_WR: begin
                    r_mark       <= r_cur_start;
                    r_mark_vld   <= 1'b1;
                    r_res_status <= hba_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                S_SH_RD: begin
                    r_state <= (r_sh == r_sh_end) ? r_ret : S_SH_WR;
                end
                S_SH_WR: begin
                    r_sh    <= r_sh_dn ? r_sh - hba_pkg::IDX_W'(1)
                                       : r_sh + hba_pkg::IDX_W'(1);
                    r_state <= S_SH_RD;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_vld || rsp.ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_data   <= r_res_data;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
